/* rtl/ssea_pkg.sv */
package ssea_pkg;

    // field widths fixed by the interface
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 7;
    localparam int ADDR_W     = 32;
    localparam int IDX_W      = 6;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // operation codes of an input word
    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_SCAN  = 2'd1,
        OP_BEGIN = 2'd2
    } t_op;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT     = 1'b1;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic              shift;
        logic              clear;
        logic              load;
        logic [IDX_W-1:0]  load_index;
        logic [BYTE_W-1:0] load_byte;
    } t_cell_ctrl;

endpackage

/* rtl/ssea_cell.sv */
module ssea_cell
    import ssea_pkg::*;
#(
    parameter int CELL_ID = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic [BYTE_W-1:0] i_win_in,
    input  logic [BYTE_W-1:0] i_aligned,
    input  logic              i_active,
    output logic [BYTE_W-1:0] o_win,
    output logic [BYTE_W-1:0] o_pat,
    output logic              o_hit
);

    logic [BYTE_W-1:0] r_win;
    logic [BYTE_W-1:0] r_pat;
    logic [BYTE_W-1:0] r_aligned;
    logic              pat_sel;

    assign pat_sel = i_ctrl.load && (32'(i_ctrl.load_index) == CELL_ID);

    // window byte, handed on by the right neighbour
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_ctrl.clear) begin
            r_win <= '0;
        end else if (i_ctrl.shift) begin
            r_win <= i_win_in;
        end
    end

    // signature byte at this store position, and the byte lined up with this slot
    always_ff @(posedge i_clk) begin
        if (pat_sel) begin
            r_pat <= i_ctrl.load_byte;
        end
        r_aligned <= i_aligned;
    end

    // compare against the byte that enters this slot on the shift
    assign o_hit = !i_active || (i_win_in == r_aligned);
    assign o_win = r_win;
    assign o_pat = r_pat;

endmodule

/* rtl/ssea_page.sv */
module ssea_page
    import ssea_pkg::*;
#(
    parameter int PAGE_BYTES  = 4096,
    parameter int MAX_PATTERN = 64,
    parameter int PW          = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_scan,
    input  logic             i_clear,
    input  logic [PW-1:0]    i_offset,
    input  logic [LEN_W-1:0] i_len,
    input  logic             i_win_match,
    output logic             o_match
);

    localparam int FW = $clog2(PAGE_BYTES + 1);

    logic [FW-1:0]    r_fill, n_fill;
    logic [LEN_W-1:0] r_skip, n_skip;
    logic [FW-1:0]    fill_base, fill_new;
    logic [LEN_W-1:0] skip_base, skip_dec;
    logic             first_byte, can_end, len_ok, fill_ok, offset_ok;

    // page bookkeeping for the byte being scanned
    always_comb begin
        first_byte = (i_offset == '0);
        fill_base  = first_byte ? '0 : r_fill;
        skip_base  = first_byte ? '0 : r_skip;
        fill_new   = (fill_base < FW'(PAGE_BYTES)) ? fill_base + FW'(1) : fill_base;
        can_end    = (skip_base == '0);
        skip_dec   = can_end ? skip_base : skip_base - LEN_W'(1);
        len_ok     = (i_len != '0) && (32'(i_len) <= MAX_PATTERN)
                     && (32'(i_len) <= PAGE_BYTES);
        fill_ok    = 32'(fill_new) >= 32'(i_len);
        offset_ok  = (32'(i_offset) + 32'd1) >= 32'(i_len);
        o_match    = i_scan && len_ok && can_end && fill_ok && offset_ok && i_win_match;
    end

    // next count values
    always_comb begin
        n_fill = r_fill;
        n_skip = r_skip;
        if (i_clear) begin
            n_fill = '0;
            n_skip = '0;
        end else if (i_scan) begin
            n_fill = fill_new;
            n_skip = o_match ? i_len - LEN_W'(1) : skip_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_skip <= '0;
        end else begin
            r_fill <= n_fill;
            r_skip <= n_skip;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= PAGE_BYTES)
        else $error("page fill count beyond page size");

    a_skip_after_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_match |=> (r_skip == $past(i_len - LEN_W'(1))))
        else $error("skip count not loaded after a match");

endmodule

/* rtl/signature_scan_erase.sv */
// one result word at most per scanned byte, registered and presented in the cycle after that byte is taken
// scan bytes and begin-scan words are taken one per cycle while no load, configuration or output stall holds the input
// after a pattern load the input stalls while the lined-up pattern row is re-registered
// a configuration write stalls the input in the same way, for the same reason
// synchronous active-low reset clears the window, counts, registers and output valid;
// the pattern store is not cleared
module signature_scan_erase
    import ssea_pkg::*;
#(
    parameter int PAGE_BYTES  = 4096,
    parameter int MAX_PATTERN = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [IDX_W-1:0]      i_pattern_index,
    input  logic [BYTE_W-1:0]     i_byte_value,
    input  logic [ADDR_W-1:0]     i_byte_address,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [ADDR_W-1:0]     o_match_address
);

    // page size is taken as a power of two
    localparam int PW = $clog2(PAGE_BYTES);
    localparam int SW = $clog2(MAX_PATTERN + 1);
    localparam int VW = MAX_PATTERN * BYTE_W;

    logic [LEN_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_limit;
    logic              r_busy;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_match_address;

    logic              in_acc, load_go, scan_go, clear_go, page_ok, match;
    logic [ADDR_W-1:0] page_start;
    logic [SW-1:0]     align_shift;
    logic [VW-1:0]     pat_vec, aligned_vec;
    logic [MAX_PATTERN-1:0] hits;
    logic [BYTE_W-1:0] win [MAX_PATTERN];
    logic [BYTE_W-1:0] pat [MAX_PATTERN];
    t_cell_ctrl        ctrl;

    // input handshake and word decode
    assign o_in_stall = r_busy || (r_out_valid && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign page_start = {i_byte_address[ADDR_W-1:PW], PW'(0)};
    assign page_ok    = page_start < r_limit;
    assign load_go    = in_acc && (i_operation == OP_LOAD)
                        && (32'(i_pattern_index) < MAX_PATTERN);
    assign scan_go    = in_acc && (i_operation == OP_SCAN) && page_ok;
    assign clear_go   = in_acc && (i_operation == OP_BEGIN);

    always_comb begin
        ctrl.shift      = scan_go;
        ctrl.clear      = clear_go;
        ctrl.load       = load_go;
        ctrl.load_index = i_pattern_index;
        ctrl.load_byte  = i_byte_value;
    end

    // line the signature up with the newest end of the window
    assign align_shift = SW'(MAX_PATTERN) - SW'(r_len);
    assign aligned_vec = pat_vec << {align_shift, 3'b000};

    // row of cells, newest byte enters at the top slot
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        localparam int AGE = MAX_PATTERN - 1 - j;
        logic [BYTE_W-1:0] win_in;
        logic              active;

        if (j == MAX_PATTERN - 1) begin : g_top
            assign win_in = i_byte_value;
        end else begin : g_mid
            assign win_in = win[j+1];
        end
        assign active = AGE < 32'(r_len);
        assign pat_vec[j*BYTE_W +: BYTE_W] = pat[j];

        ssea_cell #(
            .CELL_ID (j)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (ctrl),
            .i_win_in  (win_in),
            .i_aligned (aligned_vec[j*BYTE_W +: BYTE_W]),
            .i_active  (active),
            .o_win     (win[j]),
            .o_pat     (pat[j]),
            .o_hit     (hits[j])
        );
    end

    ssea_page #(
        .PAGE_BYTES  (PAGE_BYTES),
        .MAX_PATTERN (MAX_PATTERN),
        .PW          (PW)
    ) u_page (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scan      (scan_go),
        .i_clear     (clear_go),
        .i_offset    (i_byte_address[PW-1:0]),
        .i_len       (r_len),
        .i_win_match (&hits),
        .o_match     (match)
    );

    // configuration registers and the stall after a load or configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_limit <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_busy <= load_go || i_cfg_we;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PATTERN_LENGTH: r_len   <= i_cfg_data[LEN_W-1:0];
                    CFG_SCAN_LIMIT:     r_limit <= i_cfg_data[ADDR_W-1:0];
                endcase
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= match;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (in_acc && match) begin
            r_match_address <= i_byte_address - ADDR_W'(r_len - LEN_W'(1));
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_match_address = r_match_address;

    a_load_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_go |=> o_in_stall)
        else $error("word taken while pattern row realigns");

    a_cfg_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_in_stall)
        else $error("word taken right after a configuration write");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(scan_go))
        else $error("result word without a scanned byte");

endmodule
